FILE: hw/rtl/emr_pkg.sv
package emr_pkg;

    localparam int BUF_BYTES  = 16;
    localparam int IDX_W      = $clog2(BUF_BYTES);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MIN  = 2'd2;

    localparam logic [5:0] NOMINAL_RESET   = 6'd28;
    localparam logic [3:0] TOLERANCE_RESET = 4'd6;
    localparam logic [7:0] SYNC_MIN_RESET  = 8'd8;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_1T,
        CLS_2T,
        CLS_3T
    } t_class;

    typedef enum logic {
        CMD_SAMPLE,
        CMD_FLUSH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [IDX_W-1:0] byte_idx;
        logic [2:0]       bit_idx;
        logic             level;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_WRITE,
        BK_FLUSH
    } t_back_state;

endpackage

FILE: hw/rtl/emr_front.sv
module emr_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [emr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [emr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_ticks,
    input  logic                          i_level,
    input  logic                          i_fifo_full,
    output logic                          o_cmd_push,
    output emr_pkg::t_cmd                 o_cmd
);
    import emr_pkg::*;

    logic [5:0]       r_nominal;
    logic [3:0]       r_tolerance;
    logic [7:0]       r_sync_min;

    logic             r_rx_data, n_rx_data;
    logic [7:0]       r_sync_seen, n_sync_seen;
    logic [IDX_W-1:0] r_byte, n_byte;
    logic [2:0]       r_bit, n_bit;
    logic             r_skip, n_skip;

    logic signed [9:0] lo1, lo2, lo3, hi1, hi2, hi3, tk;
    t_class            cls;
    logic              accept, emit, sample, resync, handle;

    // interval windows: n * (nominal -/+ tolerance), lower bound may go negative
    always_comb begin
        lo1 = $signed(10'(r_nominal) - 10'(r_tolerance));
        lo2 = lo1 <<< 1;
        lo3 = lo1 + lo2;
        hi1 = $signed(10'(r_nominal) + 10'(r_tolerance));
        hi2 = hi1 <<< 1;
        hi3 = hi1 + hi2;
        tk  = $signed(10'(i_ticks));
        priority if (tk >= lo1 && tk <= hi1) begin
            cls = CLS_1T;
        end else if (tk >= lo2 && tk <= hi2) begin
            cls = CLS_2T;
        end else if (tk >= lo3 && tk <= hi3) begin
            cls = CLS_3T;
        end else begin
            cls = CLS_NONE;
        end
    end

    assign o_ready = !i_fifo_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_rx_data   = r_rx_data;
        n_sync_seen = r_sync_seen;
        n_byte      = r_byte;
        n_bit       = r_bit;
        n_skip      = r_skip;
        resync      = 1'b0;
        sample      = 1'b0;
        handle      = r_rx_data;

        if (!r_rx_data) begin
            if (cls == CLS_3T) begin
                if (r_sync_seen != 8'hFF) begin
                    n_sync_seen = r_sync_seen + 8'd1;
                end
            end else if (cls == CLS_NONE || r_sync_seen < r_sync_min) begin
                resync = 1'b1;
            end else begin
                n_rx_data = 1'b1;
                handle    = 1'b1;
            end
        end

        if (handle) begin
            if (cls == CLS_1T) begin
                if (r_skip) begin
                    n_skip = 1'b0;
                end else begin
                    sample = 1'b1;
                    n_skip = 1'b1;
                end
            end else if (cls == CLS_2T) begin
                sample = 1'b1;
            end else begin
                resync = 1'b1;
            end
        end

        if (sample) begin
            n_bit = r_bit + 3'd1;
            if (r_bit == 3'd7) begin
                n_byte = (r_byte == IDX_W'(BUF_BYTES - 1)) ? '0 : r_byte + IDX_W'(1);
            end
        end

        if (resync) begin
            n_sync_seen = '0;
            n_byte      = '0;
            n_bit       = '0;
            n_skip      = 1'b0;
            n_rx_data   = 1'b0;
        end

        // a resync with an empty frame flushes nothing
        emit            = sample || (resync && r_byte != '0);
        o_cmd.kind      = sample ? CMD_SAMPLE : CMD_FLUSH;
        o_cmd.byte_idx  = r_byte;
        o_cmd.bit_idx   = r_bit;
        o_cmd.level     = i_level;
        o_cmd_push      = accept && emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal   <= NOMINAL_RESET;
            r_tolerance <= TOLERANCE_RESET;
            r_sync_min  <= SYNC_MIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NOMINAL:   r_nominal   <= i_cfg_wdata[5:0];
                CFG_TOLERANCE: r_tolerance <= i_cfg_wdata[3:0];
                CFG_SYNC_MIN:  r_sync_min  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_data   <= 1'b0;
            r_sync_seen <= '0;
            r_byte      <= '0;
            r_bit       <= '0;
            r_skip      <= 1'b0;
        end else if (accept) begin
            r_rx_data   <= n_rx_data;
            r_sync_seen <= n_sync_seen;
            r_byte      <= n_byte;
            r_bit       <= n_bit;
            r_skip      <= n_skip;
        end
    end

endmodule

FILE: hw/rtl/emr_cmd_fifo.sv
module emr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  emr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output emr_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import emr_pkg::*;

    t_cmd                  r_slot [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_PTR_W:0]   r_count;
    logic                  do_push, do_pop;

    assign o_full  = (r_count == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (FIFO_PTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (FIFO_PTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/emr_back.sv
module emr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  emr_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_last
);
    import emr_pkg::*;

    t_back_state      r_state, n_state;
    logic [7:0]       r_mem [BUF_BYTES];
    logic [BUF_BYTES-1:0] r_written;
    logic [7:0]       r_rd_data;
    logic             r_rd_written;
    logic             r_rd_pending, n_rd_pending;
    logic [IDX_W-1:0] r_wr_addr, n_wr_addr;
    logic [7:0]       r_wr_mask, n_wr_mask;
    logic [IDX_W:0]   r_issue, n_issue;
    logic [IDX_W-1:0] r_emit, n_emit;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_data, n_out_data;
    logic             r_out_last, n_out_last;

    logic             can_load, rd_en, wr_en, clear_all, load_last;
    logic [IDX_W-1:0] rd_addr;

    assign can_load = !r_out_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        n_rd_pending = r_rd_pending;
        n_wr_addr    = r_wr_addr;
        n_wr_mask    = r_wr_mask;
        n_issue      = r_issue;
        n_emit       = r_emit;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_issue[IDX_W-1:0];
        wr_en        = 1'b0;
        clear_all    = 1'b0;
        load_last    = (r_emit == IDX_W'(BUF_BYTES - 1));

        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == CMD_SAMPLE) begin
                        // read-modify-write: fetch the byte now, merge the bit next cycle
                        rd_en     = 1'b1;
                        rd_addr   = i_cmd.byte_idx;
                        n_wr_addr = i_cmd.byte_idx;
                        n_wr_mask = i_cmd.level ? (8'h80 >> i_cmd.bit_idx) : 8'h00;
                        n_state   = BK_WRITE;
                    end else begin
                        n_issue      = '0;
                        n_emit       = '0;
                        n_rd_pending = 1'b0;
                        n_state      = BK_FLUSH;
                    end
                end
            end
            BK_WRITE: begin
                wr_en   = 1'b1;
                n_state = BK_IDLE;
            end
            BK_FLUSH: begin
                if (r_rd_pending && can_load) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_rd_written ? r_rd_data : 8'h00;
                    n_out_last   = load_last;
                    n_emit       = r_emit + IDX_W'(1);
                    n_rd_pending = 1'b0;
                    if (load_last) begin
                        clear_all = 1'b1;
                        n_state   = BK_IDLE;
                    end
                end
                // read one byte ahead of the output register
                if (r_issue < (IDX_W + 1)'(BUF_BYTES) && (!r_rd_pending || can_load)) begin
                    rd_en        = 1'b1;
                    n_rd_pending = 1'b1;
                    n_issue      = r_issue + (IDX_W + 1)'(1);
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data    <= r_mem[rd_addr];
            r_rd_written <= r_written[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_wr_addr] <= (r_rd_written ? r_rd_data : 8'h00) | r_wr_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_wr_mask  <= n_wr_mask;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        r_issue    <= n_issue;
        r_emit     <= n_emit;
    end

    // entries not written since reset or the last flush read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear_all) begin
            r_written <= '0;
        end else if (wr_en) begin
            r_written[r_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_rd_pending <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_pending <= n_rd_pending;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_data;
    assign o_last  = r_out_last;

endmodule

FILE: hw/rtl/edge_interval_manchester_receiver.sv
// Manchester receiver working on edge intervals. Each transfer on the slave side is one line
// edge: the ticks since the previous edge and the line level after it. An edge is taken
// whenever the four-entry command queue has room; classification and sync/data tracking
// happen at once in the front end. The back end handles each data bit as a read and then a
// merge write on the single-port frame buffer and, on a resync with a non-empty frame, streams
// all sixteen buffer bytes out with tlast on the final one. The buffer reads as zero after
// reset and after each flush, so no clearing pass is needed and edges are taken as soon as
// reset is released.
module edge_interval_manchester_receiver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [emr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [emr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [15:0]                    i_s_tdata,   // elapsed_ticks[7:0], line_level[8]
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata,   // frame_byte[7:0]
    output logic                           o_m_tlast
);
    import emr_pkg::*;

    t_cmd push_cmd, pop_cmd;
    logic cmd_push, cmd_pop, fifo_full, fifo_empty;

    emr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_ticks     (i_s_tdata[7:0]),
        .i_level     (i_s_tdata[8]),
        .i_fifo_full (fifo_full),
        .o_cmd_push  (cmd_push),
        .o_cmd       (push_cmd)
    );

    emr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (push_cmd),
        .o_full  (fifo_full),
        .i_pop   (cmd_pop),
        .o_cmd   (pop_cmd),
        .o_empty (fifo_empty)
    );

    emr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (fifo_empty),
        .i_cmd   (pop_cmd),
        .o_pop   (cmd_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_push |-> !fifo_full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !fifo_empty)
        else $error("command popped from an empty queue");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output transfer changed while stalled");

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("output valid just after reset");

endmodule

FILE: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import emr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_PHASES = 3;
    localparam int PHASE_EDGES   = 12;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_rx_byte;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [15:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;
    logic                  m_tlast;

    // predicted receiver state
    logic [5:0]       nominal_cfg;
    logic [3:0]       tolerance_cfg;
    logic [7:0]       sync_min_cfg;
    logic             in_data;
    logic [7:0]       sync_tally;
    logic [IDX_W-1:0] byte_pos;
    logic [2:0]       bit_pos;
    logic             half_skip;
    logic [7:0]       frame_mem [BUF_BYTES];
    t_rx_byte         pending_bytes [$];

    int fail_count   = 0;
    int cycle_count  = 0;
    int edges_sent   = 0;
    bit src_steady   = 1'b0;
    bit sink_steady  = 1'b0;
    int hold_request = 0;
    int hold_left    = 0;

    edge_interval_manchester_receiver dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic t_class classify(input logic [7:0] ticks);
        int lo;
        int hi;
        for (int n = 1; n <= 3; n++) begin
            lo = n * (int'(nominal_cfg) - int'(tolerance_cfg));
            hi = n * (int'(nominal_cfg) + int'(tolerance_cfg));
            if (int'(ticks) >= lo && int'(ticks) <= hi)
                return t_class'(n);
        end
        return CLS_NONE;
    endfunction

    function automatic void clear_frame();
        for (int i = 0; i < BUF_BYTES; i++)
            frame_mem[i] = 8'h00;
    endfunction

    function automatic void reset_tracking();
        in_data    = 1'b0;
        sync_tally = 8'd0;
        byte_pos   = '0;
        bit_pos    = 3'd0;
        half_skip  = 1'b0;
    endfunction

    // msb first; the byte index wraps with its width
    function automatic void store_bit(input logic level);
        frame_mem[byte_pos][3'd7 - bit_pos] = frame_mem[byte_pos][3'd7 - bit_pos] | level;
        bit_pos = bit_pos + 3'd1;
        if (bit_pos == 3'd0)
            byte_pos = byte_pos + 1'b1;
    endfunction

    function automatic void predict_edge(input logic [7:0] ticks, input logic level);
        t_class   cls;
        logic     resync;
        logic     handle;
        t_rx_byte beat;
        cls    = classify(ticks);
        resync = 1'b0;
        handle = in_data;
        if (!in_data) begin
            if (cls == CLS_3T) begin
                if (sync_tally != 8'hFF)
                    sync_tally = sync_tally + 8'd1;
            end else if (cls == CLS_NONE || sync_tally < sync_min_cfg) begin
                resync = 1'b1;
            end else begin
                in_data = 1'b1;
                handle  = 1'b1;
            end
        end
        if (handle) begin
            unique case (cls)
                CLS_1T: begin
                    if (half_skip) begin
                        half_skip = 1'b0;
                    end else begin
                        store_bit(level);
                        half_skip = 1'b1;
                    end
                end
                CLS_2T: store_bit(level);
                default: resync = 1'b1;
            endcase
        end
        if (resync) begin
            // an empty or wrapped frame is dropped and its bytes kept
            if (byte_pos != 0) begin
                for (int i = 0; i < BUF_BYTES; i++) begin
                    beat.value = frame_mem[i];
                    beat.last  = (i == BUF_BYTES - 1);
                    pending_bytes.push_back(beat);
                end
                clear_frame();
            end
            reset_tracking();
        end
    endfunction

    // ---------------------------------------------------------------- output side

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= sink_steady || ($urandom_range(99) >= 36);
            end
        end
    end

    always @(posedge clk) begin : check_output
        t_rx_byte want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected transfer: frame_byte %0d frame_last %0d", m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (m_tdata !== want.value) begin
                    $error("frame_byte expected %0d actual %0d", want.value, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("frame_last expected %0d actual %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus helpers

    // random tick count that lands in the wanted class under the current windows
    function automatic logic [7:0] ticks_for(input t_class cls);
        int lo;
        int hi;
        int pick;
        if (cls == CLS_NONE) begin
            repeat (16) begin
                pick = $urandom_range(255);
                if (classify(pick[7:0]) == CLS_NONE)
                    return pick[7:0];
            end
            return 8'd255;
        end
        lo = int'(cls) * (int'(nominal_cfg) - int'(tolerance_cfg));
        hi = int'(cls) * (int'(nominal_cfg) + int'(tolerance_cfg));
        if (lo < 0)
            lo = 0;
        repeat (16) begin
            pick = $urandom_range(hi, lo);
            if (classify(pick[7:0]) == cls)
                return pick[7:0];
        end
        return hi[7:0];
    endfunction

    task automatic send_edge(input logic [7:0] ticks, input logic level);
        @(negedge clk);
        while (!src_steady && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, level, ticks};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_edge(ticks, level);
        edges_sent++;
    endtask

    task automatic send_sync(input int count);
        repeat (count)
            send_edge(ticks_for(CLS_3T), 1'($urandom_range(1)));
    endtask

    task automatic send_data(input int count);
        repeat (count)
            send_edge(ticks_for($urandom_range(1) ? CLS_1T : CLS_2T), 1'($urandom_range(1)));
    endtask

    task automatic send_samples(input int count);
        repeat (count)
            send_edge(ticks_for(CLS_2T), 1'($urandom_range(1)));
    endtask

    // wait until the block has drained, including sample writes that emit nothing
    task automatic quiesce();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic configure(input logic [5:0] nominal, input logic [3:0] tolerance,
                             input logic [7:0] sync_min);
        quiesce();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_NOMINAL;
        cfg_wdata <= {2'b00, nominal};
        @(negedge clk);
        cfg_index <= CFG_TOLERANCE;
        cfg_wdata <= {4'h0, tolerance};
        @(negedge clk);
        cfg_index <= CFG_SYNC_MIN;
        cfg_wdata <= sync_min;
        @(negedge clk);
        cfg_we <= 1'b0;
        nominal_cfg   = nominal;
        tolerance_cfg = tolerance;
        sync_min_cfg  = sync_min;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_defaults();
        send_edge(8'd0, 1'b0);      // below every window
        send_edge(8'd255, 1'b1);
        send_edge(8'd66, 1'b1);     // 2T and 3T windows overlap: 2T wins, too early for data
        send_edge(8'd69, 1'b0);
        send_edge(8'd102, 1'b1);
        send_sync(6);
        send_edge(8'd22, 1'b1);     // first half of a 1T pair samples
        send_edge(8'd34, 1'b0);
        send_edge(8'd44, 1'b0);
        send_edge(8'd68, 1'b1);
        send_samples(5);
        send_edge(8'd35, 1'b0);
    endtask

    task automatic test_window_extremes();
        configure(6'd63, 4'd0, 8'd0);
        send_edge(8'd62, 1'b1);
        send_edge(8'd63, 1'b1);     // no sync needed, data starts at once
        send_edge(8'd63, 1'b0);
        repeat (8)
            send_edge(8'd126, 1'($urandom_range(1)));
        send_edge(8'd189, 1'b0);    // 3T while in data mode ends the frame
        configure(6'd1, 4'd15, 8'd0);
        send_edge(8'd0, 1'b1);      // lower bound below zero admits zero
        send_edge(8'd16, 1'b0);
        send_samples(8);
        send_edge(8'd255, 1'b1);
    endtask

    task automatic test_stalled_output();
        configure(NOMINAL_RESET, TOLERANCE_RESET, 8'd1);
        hold_request = 500;
        repeat (2) begin
            send_sync(1);
            send_samples(9);
            send_edge(ticks_for(CLS_NONE), 1'($urandom_range(1)));
        end
    endtask

    task automatic send_random_burst();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            send_sync(sync_min_cfg + $urandom_range(2));
            send_data($urandom_range(20, 10));
            send_edge(ticks_for($urandom_range(1) ? CLS_3T : CLS_NONE), 1'($urandom_range(1)));
        end else if (roll < 80 && sync_min_cfg != 0) begin
            send_sync($urandom_range(sync_min_cfg - 1, 0));
            send_edge(ticks_for(CLS_2T), 1'($urandom_range(1)));
        end else if (roll < 90) begin
            // aborted inside the first byte
            send_sync(sync_min_cfg);
            send_data($urandom_range(6, 1));
            send_edge(ticks_for(CLS_NONE), 1'($urandom_range(1)));
        end else begin
            repeat ($urandom_range(4, 1))
                send_edge(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_random_frames();
        int phase_start;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure(6'($urandom_range(63, 1)), 4'($urandom_range(15, 0)),
                      8'($urandom_range(3, 0)));
            // second phase runs with no gaps on either side
            src_steady  = (phase == 1);
            sink_steady = (phase == 1);
            phase_start = edges_sent;
            while (edges_sent - phase_start < PHASE_EDGES)
                send_random_burst();
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_NOMINAL;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        nominal_cfg   = NOMINAL_RESET;
        tolerance_cfg = TOLERANCE_RESET;
        sync_min_cfg  = SYNC_MIN_RESET;
        reset_tracking();
        clear_frame();
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;

        test_directed_defaults();
        test_window_extremes();
        test_stalled_output();
        test_random_frames();

        quiesce();
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
